/* rtl/core/fpcc_pkg.sv */
// Shared types, codes and the bootstrap image of the front panel console controller.
package fpcc_pkg;

  typedef logic [15:0] word_t;

  localparam int BOOT_WORDS_DEF = 14;
  localparam int BOOT_WORDS_MAX = 14;

  // Input opcodes
  localparam logic [3:0] OP_KEYNEXT  = 4'd0;
  localparam logic [3:0] OP_KEYPREV  = 4'd1;
  localparam logic [3:0] OP_TOGGLE   = 4'd2;
  localparam logic [3:0] OP_LOADADDR = 4'd3;
  localparam logic [3:0] OP_DEPOSIT  = 4'd4;
  localparam logic [3:0] OP_EXAMINE  = 4'd5;
  localparam logic [3:0] OP_READRET  = 4'd6;
  localparam logic [3:0] OP_CONTINUE = 4'd7;
  localparam logic [3:0] OP_ENABLE   = 4'd8;
  localparam logic [3:0] OP_START    = 4'd9;
  localparam logic [3:0] OP_BOOT     = 4'd10;
  localparam logic [3:0] OP_BUSRD    = 4'd11;
  localparam logic [3:0] OP_BUSWR    = 4'd12;
  localparam logic [3:0] OP_BUSRESET = 4'd13;

  // Result actions
  localparam logic [3:0] ACT_NONE     = 4'd0;
  localparam logic [3:0] ACT_BUSRESET = 4'd1;
  localparam logic [3:0] ACT_WRREG    = 4'd2;
  localparam logic [3:0] ACT_WRBUS    = 4'd3;
  localparam logic [3:0] ACT_RDREG    = 4'd4;
  localparam logic [3:0] ACT_RDBUS    = 4'd5;
  localparam logic [3:0] ACT_CONTINUE = 4'd6;
  localparam logic [3:0] ACT_STEP     = 4'd7;
  localparam logic [3:0] ACT_HALT     = 4'd8;
  localparam logic [3:0] ACT_SETPC    = 4'd9;
  localparam logic [3:0] ACT_BUSREPLY = 4'd10;

  // Key positions
  localparam logic [1:0] KEY_OFF   = 2'd0;
  localparam logic [1:0] KEY_POWER = 2'd1;
  localparam logic [1:0] KEY_LOCK  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_REG_WINDOW  = 2'd0;
  localparam logic [1:0] CFG_SWITCH_ADDR = 2'd1;
  localparam logic [1:0] CFG_BOOT_ADDR   = 2'd2;

  localparam word_t REG_WINDOW_RST  = 16'd65472;
  localparam word_t SWITCH_ADDR_RST = 16'd65400;
  localparam word_t BOOT_ADDR_RST   = 16'd16356;

  // Register window spans R0..R6, two bytes each
  localparam logic [16:0] WINDOW_SPAN = 17'd13;

  localparam word_t BOOT_IMAGE [BOOT_WORDS_MAX] = '{
    16'o016701, 16'o000026, 16'o012702, 16'o000352, 16'o005211,
    16'o105711, 16'o100376, 16'o116162, 16'o000002, 16'o000000,
    16'o005267, 16'o177756, 16'o000765, 16'o177550
  };
  localparam logic [3:0] BOOT_PATCH_IDX = 4'd9;

  typedef struct packed {
    logic [3:0] action;
    word_t      target_address;
    logic [2:0] register_index;
    word_t      write_value;
    logic       bus_claimed;
  } res_t;

  // Loader word; one word carries the top two octal digits of the load address
  function automatic word_t boot_word(input logic [3:0] idx, input word_t base);
    word_t w;
    w = 16'h0000;
    if (idx == BOOT_PATCH_IDX) begin
      w = (base & 16'o170000) | 16'o007400;
    end else if (int'(idx) < BOOT_WORDS_MAX) begin
      w = BOOT_IMAGE[idx];
    end
    return w;
  endfunction

  function automatic logic in_window(input word_t a, input word_t base);
    logic [16:0] hi;
    hi = {1'b0, base} + WINDOW_SPAN;
    return (a >= base) && ({1'b0, a} <= hi);
  endfunction

endpackage

/* rtl/core/fpcc_in_if.sv */
// Input event channel of the front panel console controller.
interface fpcc_in_if import fpcc_pkg::*;;
  logic       valid;
  logic       ready;
  logic [3:0] opcode;
  logic [3:0] switch_index;
  word_t      bus_address;
  word_t      read_value;

  modport source(output valid, output opcode, output switch_index,
                 output bus_address, output read_value, input ready);
  modport sink(input valid, input opcode, input switch_index,
               input bus_address, input read_value, output ready);
endinterface

/* rtl/core/fpcc_out_if.sv */
// Result channel of the front panel console controller.
interface fpcc_out_if import fpcc_pkg::*;;
  logic       valid;
  logic       ready;
  logic [3:0] action;
  word_t      target_address;
  logic [2:0] register_index;
  word_t      write_value;
  logic       bus_claimed;
  word_t      address_lamps;
  word_t      data_lamps;
  logic [1:0] key_position;
  logic       enable_on;
  logic       last;

  modport source(output valid, output action, output target_address,
                 output register_index, output write_value, output bus_claimed,
                 output address_lamps, output data_lamps, output key_position,
                 output enable_on, output last, input ready);
  modport sink(input valid, input action, input target_address,
               input register_index, input write_value, input bus_claimed,
               input address_lamps, input data_lamps, input key_position,
               input enable_on, input last, output ready);
endinterface

/* rtl/core/front_panel_console_controller.sv */
// Front panel console controller: panel/bus event in, console actions out.
//
// Takes one panel or bus event per transfer on in_ch and answers with one or
// more result transfers on out_ch, the final one marked by last. An event is
// held in an input register and decoded by one pass of logic into the panel
// state and a result register, so events that give a single result move at
// one per cycle while out_ch takes them. Start gives two or three results
// and bootstrap insertion gives BOOT_WORDS+3 (17 by default); those extra
// results come from a small burst counter, one per cycle unless out_ch
// stalls, and the next event waits in the input register until the burst
// is out. An empty input register takes a new event even while a result
// waits in the output register. Configuration writes (cfg_we, cfg_index,
// cfg_wdata) are meant for idle times; index 3 is ignored.
module front_panel_console_controller import fpcc_pkg::*; #(
  parameter int BOOT_WORDS = BOOT_WORDS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  fpcc_in_if.sink    in_ch,
  fpcc_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  word_t      cfg_wdata
);

  localparam int CNT_W = $clog2(BOOT_WORDS + 3);
  localparam logic [CNT_W-1:0] BOOT_END = CNT_W'(BOOT_WORDS + 2);
  localparam logic [3:0] LAST_WORD_IDX = 4'(BOOT_WORDS - 1);

  // Configuration
  word_t win_base_r, sw_addr_r, boot_addr_r;

  // Panel state
  word_t      sw_r, addr_r, data_r;
  logic [1:0] key_r;
  logic       en_r, dep_r, exa_r, pend_r;
  word_t      sw_nxt, addr_nxt, data_nxt;
  logic [1:0] key_nxt;
  logic       en_nxt, dep_nxt, exa_nxt, pend_nxt;

  // Input register
  logic       s1_valid_r;
  logic [3:0] s1_op_r, s1_swidx_r;
  word_t      s1_ba_r, s1_rv_r;

  // Burst sequencer for start and bootstrap
  logic             burst_active_r, burst_boot_r;
  logic [CNT_W-1:0] burst_cnt_r, burst_end_r;
  word_t            burst_pc_r;

  // Output register
  logic       out_valid_r, out_last_r, out_en_r;
  res_t       out_res_r;
  word_t      out_alamp_r, out_dlamp_r;
  logic [1:0] out_key_r;

  logic  out_free, s1_go, burst_adv, out_load, in_ready;
  logic  start_burst, boot_burst, locked, blocked, hit;
  res_t  s1_res, burst_res, res_nxt;
  word_t dep_addr, exa_addr, burst_alamp, burst_dlamp;
  word_t bst_addr, alamp_nxt, dlamp_nxt;
  logic  last_nxt;
  logic [CNT_W-1:0] bst_k;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign burst_adv = burst_active_r && out_free;
  assign s1_go     = s1_valid_r && !burst_active_r && out_free;
  assign out_load  = burst_adv || s1_go;
  assign in_ready  = !s1_valid_r || s1_go;

  assign in_ch.ready = in_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_base_r  <= REG_WINDOW_RST;
      sw_addr_r   <= SWITCH_ADDR_RST;
      boot_addr_r <= BOOT_ADDR_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_REG_WINDOW)  win_base_r  <= cfg_wdata;
      if (cfg_index == CFG_SWITCH_ADDR) sw_addr_r   <= cfg_wdata;
      if (cfg_index == CFG_BOOT_ADDR)   boot_addr_r <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      s1_op_r    <= in_ch.opcode;
      s1_swidx_r <= in_ch.switch_index;
      s1_ba_r    <= in_ch.bus_address;
      s1_rv_r    <= in_ch.read_value;
    end
  end

  // Event decode: next panel state and the first result of the event.
  // A bootstrap jumps the state straight to its end value; the burst
  // sequencer rebuilds the intermediate lamp values.
  always_comb begin
    sw_nxt      = sw_r;
    addr_nxt    = addr_r;
    data_nxt    = data_r;
    key_nxt     = key_r;
    en_nxt      = en_r;
    dep_nxt     = dep_r;
    exa_nxt     = exa_r;
    pend_nxt    = pend_r;
    s1_res      = '0;
    start_burst = 1'b0;
    boot_burst  = 1'b0;
    locked      = (key_r == KEY_LOCK);
    blocked     = en_r || locked;
    hit         = (s1_ba_r == sw_addr_r);
    dep_addr    = dep_r ? addr_r + 16'd2 : addr_r;
    exa_addr    = exa_r ? addr_r + 16'd2 : addr_r;
    if (s1_go) begin
      unique case (s1_op_r)
        OP_KEYNEXT: begin
          if (key_r == KEY_OFF) begin
            addr_nxt = '0;
            data_nxt = '0;
            dep_nxt  = 1'b0;
            exa_nxt  = 1'b0;
            key_nxt  = KEY_POWER;
            s1_res.action = ACT_BUSRESET;
          end else if (key_r == KEY_POWER) begin
            key_nxt = KEY_LOCK;
          end
        end
        OP_KEYPREV: begin
          if (key_r == KEY_POWER) key_nxt = KEY_OFF;
          else if (key_r == KEY_LOCK) key_nxt = KEY_POWER;
        end
        OP_TOGGLE: begin
          if (!locked) sw_nxt = sw_r ^ (16'd1 << s1_swidx_r);
        end
        OP_LOADADDR: begin
          if (!blocked) begin
            addr_nxt = sw_r;
            dep_nxt  = 1'b0;
            exa_nxt  = 1'b0;
          end
        end
        OP_DEPOSIT: begin
          if (!blocked) begin
            addr_nxt = dep_addr;
            data_nxt = sw_r;
            dep_nxt  = 1'b1;
            exa_nxt  = 1'b0;
            s1_res.target_address = dep_addr;
            s1_res.write_value    = sw_r;
            if (in_window(dep_addr, win_base_r)) begin
              s1_res.action         = ACT_WRREG;
              s1_res.register_index = dep_addr[3:1];
            end else begin
              s1_res.action = ACT_WRBUS;
            end
          end
        end
        OP_EXAMINE: begin
          if (!blocked) begin
            addr_nxt = exa_addr;
            exa_nxt  = 1'b1;
            dep_nxt  = 1'b0;
            pend_nxt = 1'b1;
            s1_res.target_address = exa_addr;
            if (in_window(exa_addr, win_base_r)) begin
              s1_res.action         = ACT_RDREG;
              s1_res.register_index = exa_addr[3:1];
            end else begin
              s1_res.action = ACT_RDBUS;
            end
          end
        end
        OP_READRET: begin
          if (pend_r) begin
            data_nxt = s1_rv_r;
            pend_nxt = 1'b0;
          end
        end
        OP_CONTINUE: begin
          if (!locked) s1_res.action = en_r ? ACT_CONTINUE : ACT_STEP;
        end
        OP_ENABLE: begin
          en_nxt = !en_r;
          if (en_r) s1_res.action = ACT_HALT;
        end
        OP_START: begin
          if (!locked) begin
            addr_nxt      = '0;
            data_nxt      = '0;
            dep_nxt       = 1'b0;
            exa_nxt       = 1'b0;
            start_burst   = 1'b1;
            s1_res.action = ACT_BUSRESET;
          end
        end
        OP_BOOT: begin
          if (key_r == KEY_POWER && !en_r) begin
            sw_nxt        = boot_addr_r;
            addr_nxt      = boot_addr_r;
            data_nxt      = boot_word(LAST_WORD_IDX, boot_addr_r);
            dep_nxt       = 1'b0;
            exa_nxt       = 1'b0;
            pend_nxt      = 1'b1;
            start_burst   = 1'b1;
            boot_burst    = 1'b1;
            s1_res.action = ACT_BUSRESET;
          end
        end
        OP_BUSRD: begin
          s1_res.action         = ACT_BUSREPLY;
          s1_res.target_address = s1_ba_r;
          s1_res.bus_claimed    = hit;
          s1_res.write_value    = hit ? sw_r : 16'd0;
        end
        OP_BUSWR: begin
          s1_res.action         = ACT_BUSREPLY;
          s1_res.target_address = s1_ba_r;
          s1_res.bus_claimed    = hit;
        end
        OP_BUSRESET: begin
          addr_nxt = '0;
          data_nxt = '0;
          dep_nxt  = 1'b0;
          exa_nxt  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Burst results. Count 1 is set PC; start then may continue. Bootstrap
  // counts 2..BOOT_WORDS+1 are the deposits, the last count the examine.
  always_comb begin
    burst_res   = '0;
    burst_alamp = '0;
    burst_dlamp = '0;
    bst_k       = burst_cnt_r - CNT_W'(2);
    bst_addr    = boot_addr_r + (16'(bst_k) << 1);
    if (burst_cnt_r == CNT_W'(1)) begin
      burst_res.action         = ACT_SETPC;
      burst_res.target_address = burst_pc_r;
    end else if (!burst_boot_r) begin
      burst_res.action = ACT_CONTINUE;
    end else if (burst_cnt_r == BOOT_END) begin
      burst_res.target_address = boot_addr_r;
      burst_alamp              = boot_addr_r;
      burst_dlamp              = boot_word(LAST_WORD_IDX, boot_addr_r);
      if (in_window(boot_addr_r, win_base_r)) begin
        burst_res.action         = ACT_RDREG;
        burst_res.register_index = boot_addr_r[3:1];
      end else begin
        burst_res.action = ACT_RDBUS;
      end
    end else begin
      burst_res.target_address = bst_addr;
      burst_res.write_value    = boot_word(4'(bst_k), boot_addr_r);
      burst_alamp              = bst_addr;
      burst_dlamp              = burst_res.write_value;
      if (in_window(bst_addr, win_base_r)) begin
        burst_res.action         = ACT_WRREG;
        burst_res.register_index = bst_addr[3:1];
      end else begin
        burst_res.action = ACT_WRBUS;
      end
    end
  end

  // Panel state and burst control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r           <= '0;
      addr_r         <= '0;
      data_r         <= '0;
      key_r          <= KEY_OFF;
      en_r           <= 1'b1;
      dep_r          <= 1'b0;
      exa_r          <= 1'b0;
      pend_r         <= 1'b0;
      burst_active_r <= 1'b0;
      burst_boot_r   <= 1'b0;
      burst_cnt_r    <= '0;
      burst_end_r    <= '0;
      burst_pc_r     <= '0;
    end else begin
      sw_r   <= sw_nxt;
      addr_r <= addr_nxt;
      data_r <= data_nxt;
      key_r  <= key_nxt;
      en_r   <= en_nxt;
      dep_r  <= dep_nxt;
      exa_r  <= exa_nxt;
      pend_r <= pend_nxt;
      if (s1_go && start_burst) begin
        burst_active_r <= 1'b1;
        burst_boot_r   <= boot_burst;
        burst_cnt_r    <= CNT_W'(1);
        burst_pc_r     <= addr_r;
        if (boot_burst) burst_end_r <= BOOT_END;
        else burst_end_r <= en_r ? CNT_W'(2) : CNT_W'(1);
      end else if (burst_adv) begin
        burst_cnt_r <= burst_cnt_r + CNT_W'(1);
        if (burst_cnt_r == burst_end_r) burst_active_r <= 1'b0;
      end
    end
  end

  // Output register. The bus reset that opens a bootstrap shows the
  // cleared console, not the state the bootstrap ends in.
  always_comb begin
    if (burst_active_r) begin
      res_nxt   = burst_res;
      alamp_nxt = (key_r != KEY_OFF) ? burst_alamp : 16'd0;
      dlamp_nxt = (key_r != KEY_OFF) ? burst_dlamp : 16'd0;
      last_nxt  = (burst_cnt_r == burst_end_r);
    end else begin
      res_nxt   = s1_res;
      alamp_nxt = (key_nxt != KEY_OFF && !boot_burst) ? addr_nxt : 16'd0;
      dlamp_nxt = (key_nxt != KEY_OFF && !boot_burst) ? data_nxt : 16'd0;
      last_nxt  = !start_burst;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r   <= res_nxt;
      out_alamp_r <= alamp_nxt;
      out_dlamp_r <= dlamp_nxt;
      out_key_r   <= key_nxt;
      out_en_r    <= en_nxt;
      out_last_r  <= last_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.action         = out_res_r.action;
  assign out_ch.target_address = out_res_r.target_address;
  assign out_ch.register_index = out_res_r.register_index;
  assign out_ch.write_value    = out_res_r.write_value;
  assign out_ch.bus_claimed    = out_res_r.bus_claimed;
  assign out_ch.address_lamps  = out_alamp_r;
  assign out_ch.data_lamps     = out_dlamp_r;
  assign out_ch.key_position   = out_key_r;
  assign out_ch.enable_on      = out_en_r;
  assign out_ch.last           = out_last_r;

  // A result loaded without last must be followed by a running burst
  a_burst_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && !last_nxt |=> burst_active_r)
    else $error("non-final result without burst");

  // The burst stops right after its final result
  a_burst_ends: assert property (@(posedge clk) disable iff (!rst_n)
    burst_adv && (burst_cnt_r == burst_end_r) |=> !burst_active_r)
    else $error("burst overran its end");

  // The counter never passes the end count while running
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    burst_active_r |-> (burst_cnt_r <= burst_end_r) && (burst_cnt_r != '0))
    else $error("burst counter out of range");

  // A bootstrap always leaves a read outstanding
  a_boot_pend: assert property (@(posedge clk) disable iff (!rst_n)
    burst_active_r && burst_boot_r |-> pend_r)
    else $error("bootstrap without pending read");

endmodule
